// ----- rtl/sawh_pkg.sv -----
package sawh_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_EXTEND = 2'd1;
   localparam logic [1:0] FUNC_FREE   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // Result codes carried on rsp_tuser.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_ROOM   = 3'd1;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
   localparam logic [2:0] ST_NOT_TOP   = 3'd3;
   localparam logic [2:0] ST_SHRINK    = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   // Configuration register indexes.
   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_TOTAL = 1'b1;

   localparam int WORD_W = 32;
   localparam int HDR_W  = 2 * WORD_W;

   // Absolute top address (base plus offset) before rounding.
   localparam int ABS_W = WORD_W + 1;

endpackage

// ----- rtl/sawh_rem_unit.sv -----
module sawh_rem_unit import sawh_pkg::*; #(
   parameter int DIVISOR = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ABS_W-1:0]              operand,
   output logic                          done,
   output logic [$clog2(DIVISOR+1):0]    remainder
);

   localparam int RemW = $clog2(DIVISOR + 1) + 1;

   // Widths of the two folding sums. With a divisor of at most 64 every residue
   // is below 64, so 33 residues fit in 12 bits and 12 residues fit in 10 bits.
   localparam int Fold1W = 12;
   localparam int Fold2W = 10;

   logic                 stage1_ff;
   logic                 stage2_ff;
   logic                 done_ff;
   logic [Fold1W-1:0]    fold1_ff;
   logic [Fold2W-1:0]    fold2_ff;
   logic [RemW-1:0]      rem_ff;
   logic [Fold1W-1:0]    fold1;
   logic [Fold2W-1:0]    fold2;
   logic [Fold2W-1:0]    reduced;

   // Residue of 2^bit_pos modulo the divisor, built by doubling so that only
   // constants are ever reduced.
   function automatic int pow2_residue(input int bit_pos);
      int r;
      r = (DIVISOR == 1) ? 0 : 1;
      for (int i = 0; i < bit_pos; i++) begin
         r = r * 2;
         if (r >= DIVISOR) begin
            r = r - DIVISOR;
         end
      end
      return r;
   endfunction

   // First fold: each set operand bit contributes its weight modulo the divisor.
   always_comb begin
      fold1 = '0;
      for (int i = 0; i < ABS_W; i++) begin
         if (operand[i]) begin
            fold1 = fold1 + Fold1W'(pow2_residue(i));
         end
      end
   end

   // Second fold on the much smaller first sum.
   always_comb begin
      fold2 = '0;
      for (int i = 0; i < Fold1W; i++) begin
         if (fold1_ff[i]) begin
            fold2 = fold2 + Fold2W'(pow2_residue(i));
         end
      end
   end

   // The second sum is below sixteen times the divisor, so four conditional
   // subtractions of 8, 4, 2 and 1 times the divisor leave the remainder.
   always_comb begin
      reduced = fold2_ff;
      for (int k = 3; k >= 0; k--) begin
         if (reduced >= Fold2W'(DIVISOR << k)) begin
            reduced = reduced - Fold2W'(DIVISOR << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         fold1_ff <= fold1;
      end
      if (stage1_ff) begin
         fold2_ff <= fold2;
      end
      if (stage2_ff) begin
         rem_ff <= RemW'(reduced);
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/stack_allocator_with_headers_core.sv -----
// Stack allocator with a separate header store.
//
// Requests arrive on the req_ stream: req_tuser carries the operation (allocate,
// extend top block, free top block, clear all) and req_tdata the size, the
// alignment and the block address. Every request produces exactly one response
// beat on the rsp_ stream with a status code on rsp_tuser and the user address
// and the bytes in use on rsp_tdata. The csr_ write channel sets the pool base
// and capacity; it is always ready and should only be written while idle.
// The block works on one request at a time. A clear, a zero-size or full-store
// allocate, and an extend or free on an empty stack go from acceptance straight
// to the result state; an extend or free that reads the top header passes the
// check state first. An allocate that reaches the room check waits for a
// pipelined remainder unit to reduce the top modulo the header alignment, then
// four steps place the block and push its header. The header stack is a
// synchronous memory read at the acceptance edge. A finished response sits in an
// output register; if the receiver still holds off the previous beat, the block
// waits in its result state before it accepts the next request. Reset empties
// the stack, restores the default base and capacity, and drops any pending
// response.
module stack_allocator_with_headers_core import sawh_pkg::*; #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24,
   parameter int HEADER_ALIGN = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata: size [31:0], align_log2 [35:32], block_address [67:36], zero fill.
   input  logic [71:0] req_tdata,
   // req_tuser: func [1:0].
   input  logic [1:0]  req_tuser,
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: user_address [31:0], used_bytes [63:32].
   output logic [63:0] rsp_tdata,
   // rsp_tuser: status [2:0].
   output logic [2:0]  rsp_tuser,
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int CntW  = $clog2(MAX_BLOCKS + 1);
   localparam int IdxW  = $clog2(MAX_BLOCKS);
   localparam int RemW  = $clog2(HEADER_ALIGN + 1) + 1;
   localparam int WorkW = WORD_W + 3;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_REM   = 3'd1;
   localparam logic [2:0] S_HDR   = 3'd2;
   localparam logic [2:0] S_ALGN  = 3'd3;
   localparam logic [2:0] S_OFF   = 3'd4;
   localparam logic [2:0] S_ENDC  = 3'd5;
   localparam logic [2:0] S_CHECK = 3'd6;
   localparam logic [2:0] S_RSP   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       top_ff, top_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Request payload and work registers.
   logic [1:0]        func_ff, func_in;
   logic [31:0]       size_ff, size_in;
   logic [3:0]        align_ff, align_in;
   logic [31:0]       addr_ff, addr_in;
   logic [WorkW-1:0]  work_ff, work_in;
   logic [2:0]        status_ff, status_in;
   logic [31:0]       uaddr_ff, uaddr_in;
   logic [63:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_user_ff, rsp_user_in;

   // Header stack: bits 31..0 user offset, bits 63..32 previous top.
   logic [HDR_W-1:0]  hdr_mem [MAX_BLOCKS];
   logic [HDR_W-1:0]  mem_q_ff;
   logic              mem_we;
   logic [HDR_W-1:0]  mem_wdata;
   logic [IdxW-1:0]   rd_idx;
   logic [IdxW-1:0]   wr_idx;

   logic              rem_start;
   logic              rem_done;
   logic [RemW-1:0]   rem_value;
   logic [ABS_W-1:0]  abs_top;

   // The top entry is read every cycle; the sequencer consumes it the cycle
   // after a request is accepted, and the count cannot move in between.
   assign rd_idx  = IdxW'(count_ff - CntW'(1));
   assign wr_idx  = count_ff[IdxW-1:0];
   assign abs_top = {1'b0, base_ff} + {1'b0, top_ff};

   sawh_rem_unit #(
      .DIVISOR (HEADER_ALIGN)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .operand   (abs_top),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      logic [RemW-1:0]   adj;
      logic [15:0]       mask;
      logic [WorkW-1:0]  end_sum;
      logic [31:0]       uoff;
      logic [31:0]       old_size;
      logic [32:0]       ext_end;
      logic              match;

      state_in     = state_ff;
      base_in      = base_ff;
      total_in     = total_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      func_in      = func_ff;
      size_in      = size_ff;
      align_in     = align_ff;
      addr_in      = addr_ff;
      work_in      = work_ff;
      status_in    = status_ff;
      uaddr_in     = uaddr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_wdata    = {top_ff, work_ff[31:0]};
      rem_start    = 1'b0;

      adj      = (rem_value == '0) ? '0 : RemW'(HEADER_ALIGN) - rem_value;
      mask     = (16'd1 << align_ff) - 16'd1;
      end_sum  = work_ff + WorkW'(size_ff);
      uoff     = mem_q_ff[31:0];
      old_size = top_ff - uoff;
      ext_end  = {1'b0, uoff} + {1'b0, size_ff};
      match    = ((base_ff + uoff) == addr_ff);

      if (csr_valid) begin
         unique case (csr_index)
            REG_BASE:  base_in  = csr_data;
            REG_TOTAL: total_in = csr_data;
            default:   base_in  = base_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tuser;
               size_in   = req_tdata[31:0];
               align_in  = req_tdata[35:32];
               addr_in   = req_tdata[67:36];
               work_in   = WorkW'(abs_top);
               status_in = ST_OK;
               uaddr_in  = '0;
               unique case (req_tuser)
                  FUNC_ALLOC: begin
                     if (req_tdata[31:0] == '0) begin
                        status_in = ST_ZERO_SIZE;
                        state_in  = S_RSP;
                     end else if (count_ff >= CntW'(MAX_BLOCKS)) begin
                        status_in = ST_FULL;
                        state_in  = S_RSP;
                     end else begin
                        rem_start = 1'b1;
                        state_in  = S_REM;
                     end
                  end
                  FUNC_EXTEND, FUNC_FREE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_TOP;
                        state_in  = S_RSP;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  FUNC_CLEAR: begin
                     top_in   = '0;
                     count_in = '0;
                     state_in = S_RSP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REM: begin
            if (rem_done) begin
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            // Round the absolute top up to the header alignment.
            work_in  = work_ff + WorkW'(adj);
            state_in = S_ALGN;
         end
         S_ALGN: begin
            // Skip the header, then round up to the user alignment.
            work_in  = (work_ff + WorkW'(HEADER_BYTES) + WorkW'(mask)) & ~WorkW'(mask);
            state_in = S_OFF;
         end
         S_OFF: begin
            work_in  = work_ff - WorkW'(base_ff);
            state_in = S_ENDC;
         end
         S_ENDC: begin
            if (end_sum > WorkW'(total_ff)) begin
               status_in = ST_NO_ROOM;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CntW'(1);
               top_in   = end_sum[31:0];
               uaddr_in = work_ff[31:0] + base_ff;
            end
            state_in = S_RSP;
         end
         S_CHECK: begin
            if (!match) begin
               status_in = ST_NOT_TOP;
            end else if (func_ff == FUNC_FREE) begin
               count_in = count_ff - CntW'(1);
               top_in   = mem_q_ff[63:32];
            end else if (size_ff < old_size) begin
               status_in = ST_SHRINK;
            end else if (size_ff == old_size) begin
               status_in = ST_OK;
            end else if (ext_end > {1'b0, total_ff}) begin
               status_in = ST_NO_ROOM;
            end else begin
               top_in = ext_end[31:0];
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {top_ff, uaddr_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         total_ff     <= 32'd65536;
         top_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         total_ff     <= total_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      size_ff     <= size_in;
      align_ff    <= align_in;
      addr_ff     <= addr_in;
      work_ff     <= work_in;
      status_ff   <= status_in;
      uaddr_ff    <= uaddr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[wr_idx] <= mem_wdata;
      end
      mem_q_ff <= hdr_mem[rd_idx];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule
